// File: design/bsfe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bsfe_pkg;

    // line bit kinds, carried on tuser
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_FLAG  = 2'd0;
    localparam t_kind KIND_DATA  = 2'd1;
    localparam t_kind KIND_CRC   = 2'd2;
    localparam t_kind KIND_STUFF = 2'd3;

    // config register indexes
    typedef logic [7:0] t_cfg_idx;
    localparam t_cfg_idx REG_MAX_FRAME = 8'd0;
    localparam t_cfg_idx REG_CRC_SEED  = 8'd1;

    localparam int CRC_W = 16;
    localparam int SIZE_W = 13;

    localparam logic [7:0]       FLAG_PATTERN = 8'h7E;
    localparam logic [2:0]       STUFF_RUN    = 3'd5;
    localparam logic [CRC_W-1:0] CRC_POLY     = 16'h1021;

    // control from the sequencer to the bit-serial CRC
    typedef struct packed {
        logic load;   // take the seed
        logic step;   // clock one payload bit through the LFSR
        logic shift;  // move the remainder out, MSB first
        logic din;    // payload bit for a step
    } t_crc_ctl;

endpackage

`default_nettype wire

// File: design/bsfe_crc.sv
`timescale 1ns / 1ps
`default_nettype none

module bsfe_crc (
    input  wire                          i_clk,
    input  wire bsfe_pkg::t_crc_ctl      i_ctl,
    input  wire [bsfe_pkg::CRC_W-1:0]    i_seed,
    output logic                         o_msb
);

    logic [bsfe_pkg::CRC_W-1:0] r_crc;
    logic                       w_fb;

    assign w_fb  = r_crc[bsfe_pkg::CRC_W-1] ^ i_ctl.din;
    assign o_msb = r_crc[bsfe_pkg::CRC_W-1];

    // one bit per cycle: seed load, LFSR step, or shift-out
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_crc <= i_seed;
        end else if (i_ctl.step) begin
            r_crc <= {r_crc[bsfe_pkg::CRC_W-2:0], 1'b0}
                     ^ (w_fb ? bsfe_pkg::CRC_POLY : '0);
        end else if (i_ctl.shift) begin
            r_crc <= {r_crc[bsfe_pkg::CRC_W-2:0], 1'b0};
        end
    end

endmodule

`default_nettype wire

// File: design/bit_stuffed_frame_encoder_top.sv
`timescale 1ns / 1ps
`default_nettype none

// HDLC-style framer. Input bytes are cut into frames of at most max_frame_bytes
// (register 0, clamped to 1..MAX_FRAME_LIMIT); a byte with tlast closes the
// frame early. Each frame goes out one line bit per output word, MSB first:
// opening 0x7E flag, payload bits, CRC-16-CCITT (poly 0x1021, seed from
// register 1 latched at frame start), closing 0x7E flag. A zero is stuffed
// after five ones in payload and CRC; flags are never stuffed. One line bit
// is produced per cycle while the output is not stalled and no byte is being
// taken, by a single bit sequencer and a bit-serial CRC. A byte gives 8 data
// bits and up to 2 stuffed zeros, behind the opening flag when it opens a
// frame, and ahead of the 16 CRC bits, their stuffed zeros and the closing
// flag when it ends one. A new byte is taken once the last line bit of the
// previous one sits in the output register. Output word: tdata[0] line bit,
// tdata[1] last bit caused by the input byte; tuser bit kind; tlast marks the
// final bit of a closing flag.
module bit_stuffed_frame_encoder_top #(
    parameter int MAX_FRAME_LIMIT = 4096
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // config write channel
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [7:0]  i_cfg_index,
    input  wire  [15:0] i_cfg_data,
    // input byte stream
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire         s_axis_tlast,   // end_of_stream
    // output line bits
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [0] line_bit, [1] run_last, [7:2] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] bit_kind
    output logic        m_axis_tlast    // frame_end
);

    localparam int CNT_W = $clog2(MAX_FRAME_LIMIT + 1);
    localparam int LIM_W = (CNT_W > bsfe_pkg::SIZE_W) ? CNT_W : bsfe_pkg::SIZE_W;
    localparam logic [LIM_W-1:0] LIMIT_MAX = LIM_W'(MAX_FRAME_LIMIT);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OPEN,
        ST_DATA,
        ST_CRC,
        ST_CLOSE
    } t_state;

    // config registers
    logic [bsfe_pkg::SIZE_W-1:0] r_max;
    logic [bsfe_pkg::CRC_W-1:0]  r_seed;

    // sequencer state
    t_state            r_state, n_state;
    logic [3:0]        r_idx, n_idx;
    logic [7:0]        r_data, n_data;
    logic [2:0]        r_ones, n_ones;
    logic              r_stuff, n_stuff;
    logic              r_stuff_last, n_stuff_last;
    logic              r_close, n_close;
    logic              r_open, n_open;
    logic [CNT_W-1:0]  r_count, n_count;

    // output register
    logic              r_out_valid, n_out_valid;
    logic              r_out_bit, n_out_bit;
    bsfe_pkg::t_kind   r_out_kind, n_out_kind;
    logic              r_out_fend, n_out_fend;
    logic              r_out_last, n_out_last;

    bsfe_pkg::t_crc_ctl w_crc_ctl;
    logic               w_crc_msb;
    logic               w_take;
    logic               w_adv;
    logic [LIM_W-1:0]   w_max_ext;
    logic [LIM_W-1:0]   w_limit;
    logic [CNT_W-1:0]   w_count_base;
    logic [CNT_W-1:0]   w_count_next;
    logic [2:0]         w_ones_inc;
    logic               w_bit;

    bsfe_crc u_crc (
        .i_clk  (i_clk),
        .i_ctl  (w_crc_ctl),
        .i_seed (r_seed),
        .o_msb  (w_crc_msb)
    );

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE) && !r_stuff;
    assign w_take        = s_axis_tvalid && s_axis_tready;
    assign w_adv         = !r_out_valid || m_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_last, r_out_bit};
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_fend;

    // clamped frame size and next byte count
    assign w_max_ext    = LIM_W'(r_max);
    assign w_limit      = (w_max_ext == '0) ? LIM_W'(1)
                        : (w_max_ext > LIMIT_MAX) ? LIMIT_MAX : w_max_ext;
    assign w_count_base = r_open ? r_count : '0;
    assign w_count_next = (LIM_W'(w_count_base) < LIMIT_MAX)
                        ? w_count_base + CNT_W'(1) : w_count_base;

    // next bit of a stuffable field and the ones run it leaves
    assign w_bit      = (r_state == ST_CRC) ? w_crc_msb : r_data[7];
    assign w_ones_inc = r_ones + 3'd1;

    // bit sequencer
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_data       = r_data;
        n_ones       = r_ones;
        n_stuff      = r_stuff;
        n_stuff_last = r_stuff_last;
        n_close      = r_close;
        n_open       = r_open;
        n_count      = r_count;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_bit    = r_out_bit;
        n_out_kind   = r_out_kind;
        n_out_fend   = r_out_fend;
        n_out_last   = r_out_last;
        w_crc_ctl    = '0;

        if (w_take) begin
            n_data  = s_axis_tdata;
            n_close = s_axis_tlast || (LIM_W'(w_count_next) >= w_limit);
            n_count = w_count_next;
            n_idx   = 4'd7;
            if (!r_open) begin
                n_open         = 1'b1;
                n_ones         = 3'd0;
                n_state        = ST_OPEN;
                w_crc_ctl.load = 1'b1;
            end else begin
                n_state = ST_DATA;
            end
        end else if (w_adv) begin
            if (r_stuff) begin
                // stuffed zero takes priority over the next field bit
                n_out_valid = 1'b1;
                n_out_bit   = 1'b0;
                n_out_kind  = bsfe_pkg::KIND_STUFF;
                n_out_fend  = 1'b0;
                n_out_last  = r_stuff_last;
                n_stuff     = 1'b0;
                n_stuff_last = 1'b0;
            end else begin
                case (r_state)
                    ST_OPEN, ST_CLOSE: begin
                        n_out_valid = 1'b1;
                        n_out_bit   = bsfe_pkg::FLAG_PATTERN[r_idx[2:0]];
                        n_out_kind  = bsfe_pkg::KIND_FLAG;
                        n_out_fend  = 1'b0;
                        n_out_last  = 1'b0;
                        n_idx       = r_idx - 4'd1;
                        if (r_idx == 4'd0) begin
                            if (r_state == ST_OPEN) begin
                                n_state = ST_DATA;
                                n_idx   = 4'd7;
                            end else begin
                                n_out_fend = 1'b1;
                                n_out_last = 1'b1;
                                n_state    = ST_IDLE;
                                n_open     = 1'b0;
                                n_count    = '0;
                                n_ones     = 3'd0;
                            end
                        end
                    end
                    ST_DATA, ST_CRC: begin
                        n_out_valid = 1'b1;
                        n_out_bit   = w_bit;
                        n_out_kind  = (r_state == ST_CRC) ? bsfe_pkg::KIND_CRC
                                                          : bsfe_pkg::KIND_DATA;
                        n_out_fend  = 1'b0;
                        n_out_last  = 1'b0;
                        n_idx       = r_idx - 4'd1;
                        if (r_state == ST_CRC) begin
                            w_crc_ctl.shift = 1'b1;
                        end else begin
                            w_crc_ctl.step = 1'b1;
                            w_crc_ctl.din  = w_bit;
                            n_data         = {r_data[6:0], 1'b0};
                        end
                        // ones run and stuffing
                        if (!w_bit) begin
                            n_ones = 3'd0;
                        end else if (w_ones_inc == bsfe_pkg::STUFF_RUN) begin
                            n_ones  = 3'd0;
                            n_stuff = 1'b1;
                        end else begin
                            n_ones = w_ones_inc;
                        end
                        if (r_idx == 4'd0) begin
                            if (r_state == ST_CRC) begin
                                n_state = ST_CLOSE;
                                n_idx   = 4'd7;
                            end else if (r_close) begin
                                n_state = ST_CRC;
                                n_idx   = 4'd15;
                            end else begin
                                // byte ends here or on its trailing stuffed zero
                                n_state      = ST_IDLE;
                                n_out_last   = !n_stuff;
                                n_stuff_last = n_stuff;
                                n_count      = r_count;
                            end
                        end
                    end
                    default: begin
                        n_state = r_state;
                    end
                endcase
            end
        end
    end

    // config writes, sequencer state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max        <= bsfe_pkg::SIZE_W'(64);
            r_seed       <= 16'hFFFF;
            r_state      <= ST_IDLE;
            r_idx        <= 4'd0;
            r_ones       <= 3'd0;
            r_stuff      <= 1'b0;
            r_stuff_last <= 1'b0;
            r_close      <= 1'b0;
            r_open       <= 1'b0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    bsfe_pkg::REG_MAX_FRAME: r_max  <= i_cfg_data[bsfe_pkg::SIZE_W-1:0];
                    bsfe_pkg::REG_CRC_SEED:  r_seed <= i_cfg_data;
                    default: begin
                        r_max <= r_max;
                    end
                endcase
            end
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_ones       <= n_ones;
            r_stuff      <= n_stuff;
            r_stuff_last <= n_stuff_last;
            r_close      <= n_close;
            r_open       <= n_open;
            r_count      <= n_count;
            r_out_valid  <= n_out_valid;
        end
        r_data     <= n_data;
        r_out_bit  <= n_out_bit;
        r_out_kind <= n_out_kind;
        r_out_fend <= n_out_fend;
        r_out_last <= n_out_last;
    end

    // a closing flag bit always ends the byte's run and is a flag bit
    a_fend_is_flag_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |->
            (m_axis_tuser == bsfe_pkg::KIND_FLAG) && m_axis_tdata[1])
        else $error("frame end not on a last flag bit");

    // ones run never reaches the stuffing threshold in the register
    a_ones_below_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ones < bsfe_pkg::STUFF_RUN)
        else $error("ones run overflow");

    // byte count stays within MAX_FRAME_LIMIT
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LIM_W'(r_count) <= LIMIT_MAX)
        else $error("frame byte count past limit");

    // a byte taken with no frame open starts with the opening flag
    a_open_after_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && !r_open) |=> (r_state == ST_OPEN) && r_open)
        else $error("frame did not open");

endmodule

`default_nettype wire
